/* hdl/bba_pkg.sv */
// Shared constants and types for the buddy block allocator.
package bba_pkg;

    localparam int TOP_ORDER_DEF   = 10;
    localparam int OFFSET_BITS_DEF = 12;

    localparam int ORDER_W = 4;
    localparam int OFS_W   = 12;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic             ok;
        logic [OFS_W-1:0] granted;
    } t_result;

endpackage

/* hdl/buddy_block_allocator_top.sv */
// Allocate: scans the lists upward from the requested order, splits a larger block down to it
// and pops the block; a refused allocate or an out-of-range order gives a failed result.
// Free: below the top order, searches each order's list for the buddy and merges with it;
// the block is pushed where the search ends, and the result goes to the output register.
// One item at a time; the next is accepted once the previous result is taken into the output
// register. Reset empties every free list at once; the link memory is not cleared.
module buddy_block_allocator_top #(
    parameter int TOP_ORDER   = bba_pkg::TOP_ORDER_DEF,
    parameter int OFFSET_BITS = bba_pkg::OFFSET_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_mode,
    input  logic [bba_pkg::ORDER_W-1:0] i_order,
    input  logic [bba_pkg::OFS_W-1:0]   i_block_offset,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bba_pkg::OFS_W-1:0]   o_granted_offset,
    output logic                        o_ok
);

    import bba_pkg::*;

    logic                 res_valid;
    logic                 res_take;
    t_result              res;
    logic                 mem_we;
    logic [OFFSET_BITS-1:0] mem_waddr;
    logic [OFFSET_BITS:0]   mem_wdata;
    logic [OFFSET_BITS-1:0] mem_raddr;
    logic [OFFSET_BITS:0]   mem_rdata;

    logic    r_out_valid;
    t_result r_out;

    bba_ctrl #(
        .TOP_ORDER  (TOP_ORDER),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_order       (i_order),
        .i_block_offset(i_block_offset),
        .o_res_valid   (res_valid),
        .i_res_take    (res_take),
        .o_res         (res),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    bba_link_mem #(
        .ADDR_W(OFFSET_BITS),
        .DATA_W(OFFSET_BITS + 1)
    ) u_link_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign res_take = res_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_granted_offset = r_out.granted;
    assign o_ok             = r_out.ok;

endmodule

/* hdl/bba_link_mem.sv */
// Link memory holding the successor of each listed block, one write and one read port.
module bba_link_mem #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/bba_ctrl.sv */
// Sequencer for allocate and free, with the list head registers.
module bba_ctrl #(
    parameter int TOP_ORDER   = bba_pkg::TOP_ORDER_DEF,
    parameter int OFFSET_BITS = bba_pkg::OFFSET_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic [bba_pkg::ORDER_W-1:0]  i_order,
    input  logic [bba_pkg::OFS_W-1:0]    i_block_offset,
    output logic                         o_res_valid,
    input  logic                         i_res_take,
    output bba_pkg::t_result             o_res,
    output logic                         o_mem_we,
    output logic [OFFSET_BITS-1:0]       o_mem_waddr,
    output logic [OFFSET_BITS:0]         o_mem_wdata,
    output logic [OFFSET_BITS-1:0]       o_mem_raddr,
    input  logic [OFFSET_BITS:0]         i_mem_rdata
);

    import bba_pkg::*;

    localparam int OB    = OFFSET_BITS;
    localparam int LVL_W = $clog2(TOP_ORDER + 1);
    localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(TOP_ORDER);
    localparam logic [OB-1:0]    OFS_ONE  = OB'(1);
    localparam logic [OB:0]      NULL_LNK = {1'b1, {OB{1'b0}}};

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_A_SCAN  = 4'd1;
    localparam logic [3:0] S_A_SPLIT = 4'd2;
    localparam logic [3:0] S_A_SPL2  = 4'd3;
    localparam logic [3:0] S_A_POP   = 4'd4;
    localparam logic [3:0] S_F_START = 4'd5;
    localparam logic [3:0] S_F_CHECK = 4'd6;
    localparam logic [3:0] S_F_WALK  = 4'd7;
    localparam logic [3:0] S_F_UNLNK = 4'd8;
    localparam logic [3:0] S_F_PUSH  = 4'd9;
    localparam logic [3:0] S_RESP    = 4'd10;

    logic [3:0]       r_state, n_state;
    logic             r_mode, n_mode;
    logic [LVL_W-1:0] r_ord, n_ord;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [OB-1:0]    r_blk, n_blk;
    logic [OB-1:0]    r_bud, n_bud;
    logic [OB-1:0]    r_prev, n_prev;
    logic             r_has_prev, n_has_prev;
    logic [OB:0]      r_cur, n_cur;
    logic [OB:0]      r_steps, n_steps;
    logic [OB-1:0]    r_granted, n_granted;
    logic             r_ok, n_ok;

    logic [TOP_ORDER:0] r_head_null;
    logic [OB-1:0]      r_head_ofs [TOP_ORDER+1];

    logic             hd_null;
    logic [OB-1:0]    hd_ofs;
    logic             hd_we;
    logic [LVL_W-1:0] hd_wa;
    logic [OB:0]      hd_wd;
    logic [LVL_W-1:0] lvl_dn;
    logic [OB-1:0]    split_bud;

    assign hd_null   = r_head_null[r_lvl];
    assign hd_ofs    = r_head_ofs[r_lvl];
    assign lvl_dn    = r_lvl - 1'b1;
    assign split_bud = hd_ofs ^ (OFS_ONE << lvl_dn);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_ord       = r_ord;
        n_lvl       = r_lvl;
        n_blk       = r_blk;
        n_bud       = r_bud;
        n_prev      = r_prev;
        n_has_prev  = r_has_prev;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_granted   = r_granted;
        n_ok        = r_ok;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_blk;
        o_mem_wdata = NULL_LNK;
        o_mem_raddr = hd_ofs;
        hd_we       = 1'b0;
        hd_wa       = r_lvl;
        hd_wd       = NULL_LNK;
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode    = i_mode;
                    n_ord     = LVL_W'(i_order);
                    n_lvl     = LVL_W'(i_order);
                    n_blk     = OB'(i_block_offset);
                    n_granted = '0;
                    n_ok      = 1'b0;
                    if (int'(i_order) > TOP_ORDER) begin
                        n_state = S_RESP;
                    end else if (i_mode == MODE_FREE) begin
                        n_state = S_F_START;
                    end else begin
                        n_state = S_A_SCAN;
                    end
                end
            end
            S_A_SCAN: begin
                if (!hd_null) begin
                    n_state = (r_lvl == r_ord) ? S_A_POP : S_A_SPLIT;
                end else if (r_lvl == LVL_TOP) begin
                    n_state = S_RESP;
                end else begin
                    n_lvl = r_lvl + 1'b1;
                end
            end
            S_A_SPLIT: begin
                hd_we       = 1'b1;
                hd_wd       = i_mem_rdata;
                o_mem_we    = 1'b1;
                o_mem_waddr = split_bud;
                o_mem_wdata = NULL_LNK;
                n_blk       = hd_ofs;
                n_bud       = split_bud;
                n_lvl       = lvl_dn;
                n_state     = S_A_SPL2;
            end
            S_A_SPL2: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_blk;
                o_mem_wdata = {1'b0, r_bud};
                hd_we       = 1'b1;
                hd_wd       = {1'b0, r_blk};
                n_state     = S_A_SCAN;
            end
            S_A_POP: begin
                hd_we     = 1'b1;
                hd_wd     = i_mem_rdata;
                n_granted = hd_ofs;
                n_ok      = 1'b1;
                n_state   = S_RESP;
            end
            S_F_START: begin
                if (r_lvl == LVL_TOP) begin
                    n_state = S_F_PUSH;
                end else begin
                    n_bud      = r_blk ^ (OFS_ONE << r_lvl);
                    n_cur      = {hd_null, hd_ofs};
                    n_steps    = '0;
                    n_has_prev = 1'b0;
                    n_state    = S_F_CHECK;
                end
            end
            S_F_CHECK: begin
                o_mem_raddr = r_cur[OB-1:0];
                if (r_cur[OB] || r_steps[OB]) begin
                    n_state = S_F_PUSH;
                end else if (r_cur[OB-1:0] == r_bud) begin
                    n_state = S_F_UNLNK;
                end else begin
                    n_prev     = r_cur[OB-1:0];
                    n_has_prev = 1'b1;
                    n_steps    = r_steps + 1'b1;
                    n_state    = S_F_WALK;
                end
            end
            S_F_WALK: begin
                n_cur   = i_mem_rdata;
                n_state = S_F_CHECK;
            end
            S_F_UNLNK: begin
                if (r_has_prev) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_prev;
                    o_mem_wdata = i_mem_rdata;
                end else begin
                    hd_we = 1'b1;
                    hd_wd = i_mem_rdata;
                end
                if (r_bud < r_blk) begin
                    n_blk = r_bud;
                end
                n_lvl   = r_lvl + 1'b1;
                n_state = S_F_START;
            end
            S_F_PUSH: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_blk;
                o_mem_wdata = {hd_null, hd_ofs};
                hd_we       = 1'b1;
                hd_wd       = {1'b0, r_blk};
                n_ok        = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head_null <= '1;
        end else begin
            r_state <= n_state;
            if (hd_we) begin
                r_head_null[hd_wa] <= hd_wd[OB];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_ord      <= n_ord;
        r_lvl      <= n_lvl;
        r_blk      <= n_blk;
        r_bud      <= n_bud;
        r_prev     <= n_prev;
        r_has_prev <= n_has_prev;
        r_cur      <= n_cur;
        r_steps    <= n_steps;
        r_granted  <= n_granted;
        r_ok       <= n_ok;
        if (hd_we) begin
            r_head_ofs[hd_wa] <= hd_wd[OB-1:0];
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res.ok    = r_ok;
    assign o_res.granted = OFS_W'(r_granted);

    a_reject_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && int'(i_order) > TOP_ORDER) |=> (r_state == S_RESP && !r_ok))
        else $error("out-of-range order was not refused");

    a_free_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_mode == MODE_FREE) |-> (r_granted == '0))
        else $error("free reported a granted offset");

    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F_CHECK) |-> (!r_steps[OB] || r_steps[OB-1:0] == '0))
        else $error("buddy search ran past its step limit");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_RESP) |-> (!o_mem_we && !hd_we))
        else $error("list state written outside an operation");

endmodule
